// ===== rtl/lcdt_pkg.sv =====
package lcdt_pkg;

  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int OAM_DEPTH  = 160;
  localparam int OAM_AW     = $clog2(OAM_DEPTH);
  localparam int REG_COUNT  = 12;
  localparam int REG_AW     = $clog2(REG_COUNT);

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_VRAM   = 2'd3;

  localparam logic [REG_AW-1:0] REG_LCDC = REG_AW'(0);
  localparam logic [REG_AW-1:0] REG_STAT = REG_AW'(1);
  localparam logic [REG_AW-1:0] REG_LY   = REG_AW'(4);
  localparam logic [REG_AW-1:0] REG_LYC  = REG_AW'(5);

  localparam logic [8:0] HBLANK_CYCLES = 9'd51;
  localparam logic [8:0] VBLANK_CYCLES = 9'd114;
  localparam logic [8:0] OAM_CYCLES    = 9'd20;
  localparam logic [8:0] VRAM_CYCLES   = 9'd43;

  localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  localparam logic [15:0] VRAM_BASE = 16'h8000;
  localparam logic [15:0] VRAM_END  = 16'hA000;
  localparam logic [15:0] OAM_BASE  = 16'hFE00;
  localparam logic [15:0] OAM_END   = OAM_BASE + 16'(OAM_DEPTH);
  localparam logic [15:0] REG_BASE  = 16'hFF40;
  localparam logic [15:0] REG_END   = REG_BASE + 16'(REG_COUNT);

  typedef enum logic [1:0] {
    REGION_NONE,
    REGION_VRAM,
    REGION_OAM,
    REGION_REG
  } region_t;

  typedef struct packed {
    logic [7:0] reg_data;
    logic       vblank;
    logic       render;
    logic [1:0] mode;
    logic [7:0] line;
  } timer_status_t;

  function automatic region_t decode_region(input logic [15:0] addr);
    region_t r;
    r = REGION_NONE;
    if (addr >= VRAM_BASE && addr < VRAM_END) begin
      r = REGION_VRAM;
    end else if (addr >= OAM_BASE && addr < OAM_END) begin
      r = REGION_OAM;
    end else if (addr >= REG_BASE && addr < REG_END) begin
      r = REGION_REG;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lcdt_vram.sv =====
module lcdt_vram (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       rd_en,
  input  logic [lcdt_pkg::VRAM_AW-1:0] addr,
  input  logic [7:0]                 wdata,
  output logic [7:0]                 rdata,
  output logic                       cleared
);
  import lcdt_pkg::*;

  logic [7:0]         mem [VRAM_DEPTH];
  logic               clearing;
  logic [VRAM_AW-1:0] clear_addr;

  // sweep zeros through the array after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + VRAM_AW'(1);
      if (clear_addr == VRAM_AW'(VRAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= 8'd0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  assign cleared = !clearing;

endmodule

// ===== rtl/lcdt_oam.sv =====
module lcdt_oam (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [lcdt_pkg::OAM_AW-1:0] addr,
  input  logic [7:0]                  wdata,
  output logic [7:0]                  rdata
);
  import lcdt_pkg::*;

  logic [7:0] mem [OAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/lcdt_timer.sv =====
module lcdt_timer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [1:0]              command,
  input  lcdt_pkg::region_t       region,
  input  logic [lcdt_pkg::REG_AW-1:0] reg_index,
  input  logic [7:0]              write_data,
  input  logic [7:0]              elapsed_cycles,
  output lcdt_pkg::timer_status_t status
);
  import lcdt_pkg::*;

  logic [7:0] regs [REG_COUNT];
  logic [1:0] mode;
  logic [8:0] acc;
  logic [7:0] reg_data;
  logic       vblank;
  logic       render;

  logic [8:0] acc_sum;
  logic [7:0] ly;
  logic [7:0] ly_inc;
  logic [1:0] mode_next;
  logic [8:0] acc_next;
  logic [7:0] ly_next;
  logic       vblank_next;
  logic       render_next;

  assign acc_sum = acc + {1'b0, elapsed_cycles};
  assign ly      = regs[REG_LY];
  assign ly_inc  = ly + 8'd1;

  always_comb begin
    mode_next   = mode;
    acc_next    = acc_sum;
    ly_next     = ly;
    vblank_next = 1'b0;
    render_next = 1'b0;
    unique case (mode)
      MODE_HBLANK: begin
        if (acc_sum >= HBLANK_CYCLES) begin
          if (ly == LAST_VISIBLE_LINE) begin
            mode_next   = MODE_VBLANK;
            vblank_next = 1'b1;
          end else begin
            mode_next = MODE_OAM;
          end
          ly_next  = ly_inc;
          acc_next = 9'd0;
        end
      end
      MODE_VBLANK: begin
        if (acc_sum >= VBLANK_CYCLES) begin
          acc_next = 9'd0;
          ly_next  = ly_inc;
          if (ly_inc > LAST_LINE) begin
            ly_next   = 8'd0;
            mode_next = MODE_OAM;
          end
        end
      end
      MODE_OAM: begin
        if (acc_sum >= OAM_CYCLES) begin
          acc_next  = 9'd0;
          mode_next = MODE_VRAM;
        end
      end
      MODE_VRAM: begin
        if (acc_sum >= VRAM_CYCLES) begin
          acc_next    = 9'd0;
          mode_next   = MODE_HBLANK;
          render_next = regs[REG_LCDC][7];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[REG_AW'(i)] <= 8'd0;
      end
      mode     <= MODE_OAM;
      acc      <= 9'd0;
      reg_data <= 8'd0;
      vblank   <= 1'b0;
      render   <= 1'b0;
    end else if (accept) begin
      vblank   <= 1'b0;
      render   <= 1'b0;
      reg_data <= 8'd0;
      unique case (command)
        CMD_TICK: begin
          mode          <= mode_next;
          acc           <= acc_next;
          vblank        <= vblank_next;
          render        <= render_next;
          regs[REG_LY]  <= ly_next;
          regs[REG_STAT] <= {5'd0, ly_next == regs[REG_LYC], mode_next};
        end
        CMD_READ: begin
          if (region == REGION_REG) begin
            reg_data <= regs[reg_index];
          end
        end
        CMD_WRITE: begin
          if (region == REGION_REG) begin
            regs[reg_index] <= write_data;
          end
        end
        default: ;
      endcase
    end
  end

  // mode and line already hold the after-item values in the cycle after accept
  assign status.reg_data = reg_data;
  assign status.vblank   = vblank;
  assign status.render   = render;
  assign status.mode     = mode;
  assign status.line     = regs[REG_LY];

endmodule

// ===== rtl/lcd_mode_timer_and_video_memory.sv =====
// LCD mode timer and video memory.
// Input channel (in_valid/in_ready) carries one bus item: command selects a
// tick of elapsed_cycles, a read of address, or a write of write_data to
// address. Video memory, sprite attribute memory and the twelve LCD registers
// share the one address decode; unmapped addresses read 0.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// read_data, the vblank_interrupt and render_request flags, and lcd_mode and
// current_line as they stand after the item.
// Each item passes the accept cycle, where writes and the mode step happen
// and the memories are read, then the s1 stage for the registered read data
// of the synchronous RAMs, before the result is loaded into the output
// register. No new item is taken while one is held in s1; a result waiting
// in the output register holds until out_ready, and in_ready stays low until
// it is taken or leaves in the same cycle.
// After reset in_ready stays low while all 8192 bytes of video memory are
// cleared one byte a cycle; the LCD registers clear at once and the mode
// starts in OAM with the cycle count at zero.
module lcd_mode_timer_and_video_memory (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  elapsed_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        vblank_interrupt,
  output logic        render_request,
  output logic [1:0]  lcd_mode,
  output logic [7:0]  current_line
);
  import lcdt_pkg::*;

  logic          accept;
  logic          cleared;
  region_t       region;
  logic          is_read;
  logic          is_write;
  logic [7:0]    vram_rdata;
  logic [7:0]    oam_rdata;
  timer_status_t status;

  logic          s1_valid;
  region_t       s1_region;
  logic [7:0]    rdata_sel;

  assign region   = decode_region(address);
  assign is_read  = command == CMD_READ;
  assign is_write = command == CMD_WRITE;
  assign in_ready = cleared && !s1_valid && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  lcdt_vram u_vram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && is_write && region == REGION_VRAM),
    .rd_en   (accept && is_read && region == REGION_VRAM),
    .addr    (address[VRAM_AW-1:0]),
    .wdata   (write_data),
    .rdata   (vram_rdata),
    .cleared (cleared)
  );

  lcdt_oam u_oam (
    .clk   (clk),
    .wr_en (accept && is_write && region == REGION_OAM),
    .rd_en (accept && is_read && region == REGION_OAM),
    .addr  (address[OAM_AW-1:0]),
    .wdata (write_data),
    .rdata (oam_rdata)
  );

  lcdt_timer u_timer (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (command),
    .region         (region),
    .reg_index      (address[REG_AW-1:0]),
    .write_data     (write_data),
    .elapsed_cycles (elapsed_cycles),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_region <= is_read ? region : REGION_NONE;
    end
  end

  always_comb begin
    unique case (s1_region)
      REGION_VRAM: rdata_sel = vram_rdata;
      REGION_OAM:  rdata_sel = oam_rdata;
      REGION_REG:  rdata_sel = status.reg_data;
      default:     rdata_sel = 8'd0;
    endcase
  end

  // the output slot is always free when s1 holds an item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_valid) begin
      read_data        <= rdata_sel;
      vblank_interrupt <= status.vblank;
      render_request   <= status.render;
      lcd_mode         <= status.mode;
      current_line     <= status.line;
    end
  end

endmodule
